>>> design/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

  // Field widths of the input and result words.
  localparam int CmdW      = 2;
  localparam int SlotIdW   = 3;
  localparam int PrioW     = 8;
  localparam int MaskW     = 8;
  localparam int SliceW    = 4;
  // The priority bits at and above this position pick the level.
  localparam int PrioShift = 6;

  // Command codes.
  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_REQUEUE  = 2'd1,
    CMD_SCHEDULE = 2'd2
  } cmd_e;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE        = 10'b00_0000_0001,
    S_REQ_SCAN    = 10'b00_0000_0010,
    S_REQ_APPEND  = 10'b00_0000_0100,
    S_SCH_SCAN    = 10'b00_0000_1000,
    S_SCH_UNUSED  = 10'b00_0001_0000,
    S_SCH_REREAD  = 10'b00_0010_0000,
    S_SCH_BLOCKED = 10'b00_0100_0000,
    S_SCH_ROT     = 10'b00_1000_0000,
    S_SCH_TAKE    = 10'b01_0000_0000,
    S_EMIT        = 10'b10_0000_0000
  } state_e;

endpackage

>>> design/multilevel_feedback_queue_scheduler.sv
// Multilevel feedback queue scheduler: ring queues per level and a small sequencer.
//
// Usage: one input channel carries command words (clear, requeue, schedule),
// one output channel returns exactly one result word per command. Clear and
// requeue return zero; schedule returns the chosen slot (zero when idle) and
// a flag that is set when the slot's time slice ran out and it moved down (or, at the last level, to the back).
// The sequencer handles one command at a time, touching one queue entry per
// cycle; in_ready_o is high only while it waits for a command.
// A requeue reads each queued entry once to compact the levels before it
// appends the slot; a schedule visits the levels in order until one yields
// a slot or the last level is done.
// The result sits in an output register, so the next command may be accepted
// while the previous result still waits for out_ready_i; a finished result
// waits in the sequencer only when that register is still full.
// Reset empties all levels, zeroes all time slices and drops any result.
module multilevel_feedback_queue_scheduler #(
  parameter int NUM_SLOTS  = 8,
  parameter int NUM_LEVELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mlfq_pkg::CmdW-1:0]     command_i,
  input  logic [mlfq_pkg::SlotIdW-1:0]  slot_id_i,
  input  logic [mlfq_pkg::PrioW-1:0]    slot_priority_i,
  input  logic [mlfq_pkg::MaskW-1:0]    unused_mask_i,
  input  logic [mlfq_pkg::MaskW-1:0]    blocked_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mlfq_pkg::SlotIdW-1:0]  next_slot_o,
  output logic                          demoted_o
);
  import mlfq_pkg::*;

  localparam int PtrW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(NUM_SLOTS + 1);
  localparam int LvlW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam logic [CntW-1:0] CntFull  = CntW'(NUM_SLOTS);
  localparam logic [LvlW-1:0] LvlLast  = LvlW'(NUM_LEVELS - 1);
  localparam logic [PtrW-1:0] PtrLast  = PtrW'(NUM_SLOTS - 1);

  // Queue storage and per-level pointers.
  logic [SlotIdW-1:0] entries_q [NUM_LEVELS][NUM_SLOTS];
  logic [PtrW-1:0]    heads_q  [NUM_LEVELS];
  logic [PtrW-1:0]    heads_d  [NUM_LEVELS];
  logic [PtrW-1:0]    tails_q  [NUM_LEVELS];
  logic [PtrW-1:0]    tails_d  [NUM_LEVELS];
  logic [CntW-1:0]    counts_q [NUM_LEVELS];
  logic [CntW-1:0]    counts_d [NUM_LEVELS];
  logic [SliceW-1:0]  slices_q [NUM_SLOTS];

  // Sequencer registers.
  state_e              state_q, state_d;
  logic [LvlW-1:0]     lvl_q, lvl_d;
  logic [CntW-1:0]     rem_q, rem_d;
  logic [SlotIdW-1:0]  pid_q, pid_d;
  logic [SlotIdW-1:0]  id_q, id_d;
  logic [LvlW-1:0]     tgt_q, tgt_d;
  logic [MaskW-1:0]    unused_q, unused_d;
  logic [MaskW-1:0]    blocked_q, blocked_d;
  logic [SlotIdW-1:0]  res_slot_q, res_slot_d;
  logic                res_dem_q, res_dem_d;

  // Output register.
  logic                out_valid_q;
  logic [SlotIdW-1:0]  out_slot_q;
  logic                out_dem_q;

  // Single write ports of the entry and slice stores.
  logic                ent_we;
  logic [LvlW-1:0]     ent_lvl;
  logic [PtrW-1:0]     ent_ptr;
  logic [SlotIdW-1:0]  ent_data;
  logic                slc_we;
  logic [PtrW-1:0]     slc_idx;
  logic [SliceW-1:0]   slc_data;

  // Views of the current level.
  logic [PtrW-1:0]     head_cur, tail_cur;
  logic [CntW-1:0]     cnt_cur;
  logic [SlotIdW-1:0]  ent_cur;
  logic                lvl_last;
  logic [LvlW-1:0]     lvl_nx, lvl_dem;
  logic                pid_ok;
  logic [PtrW-1:0]     pidx;
  logic [SliceW-1:0]   slice_dec;
  logic [1:0]          prio_top;
  logic                out_free;
  logic                in_acc;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign next_slot_o = out_slot_q;
  assign demoted_o   = out_dem_q;

  assign head_cur  = heads_q[lvl_q];
  assign tail_cur  = tails_q[lvl_q];
  assign cnt_cur   = counts_q[lvl_q];
  assign ent_cur   = entries_q[lvl_q][head_cur];
  assign lvl_last  = (lvl_q == LvlLast);
  assign lvl_nx    = lvl_q + 1'b1;
  assign lvl_dem   = lvl_last ? lvl_q : lvl_nx;
  assign pid_ok    = 32'(pid_q) < 32'(NUM_SLOTS);
  assign pidx      = PtrW'(pid_q);
  assign slice_dec = slices_q[pidx] - 1'b1;
  assign prio_top  = slot_priority_i[PrioW-1:PrioShift];

  // Sequencer: one queue entry read and at most one entry written per cycle.
  always_comb begin
    state_d    = state_q;
    lvl_d      = lvl_q;
    rem_d      = rem_q;
    pid_d      = pid_q;
    id_d       = id_q;
    tgt_d      = tgt_q;
    unused_d   = unused_q;
    blocked_d  = blocked_q;
    res_slot_d = res_slot_q;
    res_dem_d  = res_dem_q;
    heads_d    = heads_q;
    tails_d    = tails_q;
    counts_d   = counts_q;
    ent_we     = 1'b0;
    ent_lvl    = lvl_q;
    ent_ptr    = tail_cur;
    ent_data   = pid_q;
    slc_we     = 1'b0;
    slc_idx    = pidx;
    slc_data   = slice_dec;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_slot_d = '0;
          res_dem_d  = 1'b0;
          id_d       = slot_id_i;
          unused_d   = unused_mask_i;
          blocked_d  = blocked_mask_i;
          lvl_d      = '0;
          tgt_d      = (int'(prio_top) >= NUM_LEVELS - 1) ? '0
                                                          : LvlW'(NUM_LEVELS - 1 - int'(prio_top));
          state_d    = S_EMIT;
          case (cmd_e'(command_i))
            CMD_CLEAR: begin
              for (int l = 0; l < NUM_LEVELS; l++) begin
                heads_d[l]  = '0;
                tails_d[l]  = '0;
                counts_d[l] = '0;
              end
            end
            CMD_REQUEUE: begin
              if (32'(slot_id_i) < 32'(NUM_SLOTS)) begin
                rem_d   = counts_q[0];
                state_d = S_REQ_SCAN;
              end
            end
            CMD_SCHEDULE: state_d = S_SCH_SCAN;
            default: state_d = S_EMIT;
          endcase
        end
      end

      // Compact one level in place: read each entry at the head and append
      // it again unless it is the slot being requeued.
      S_REQ_SCAN: begin
        if (rem_q == '0) begin
          if (lvl_last) begin
            state_d = S_REQ_APPEND;
          end else begin
            lvl_d = lvl_nx;
            rem_d = counts_q[lvl_nx];
          end
        end else begin
          rem_d            = rem_q - 1'b1;
          heads_d[lvl_q]   = ring_next(head_cur);
          if (ent_cur != id_q) begin
            ent_we         = 1'b1;
            ent_data       = ent_cur;
            tails_d[lvl_q] = ring_next(tail_cur);
          end else begin
            counts_d[lvl_q] = cnt_cur - 1'b1;
          end
        end
      end

      // Append the slot at its target level and reload its slice.
      S_REQ_APPEND: begin
        if (counts_q[tgt_q] < CntFull) begin
          ent_we          = 1'b1;
          ent_lvl         = tgt_q;
          ent_ptr         = tails_q[tgt_q];
          ent_data        = id_q;
          tails_d[tgt_q]  = ring_next(tails_q[tgt_q]);
          counts_d[tgt_q] = counts_q[tgt_q] + 1'b1;
        end
        slc_we   = 1'b1;
        slc_idx  = PtrW'(id_q);
        slc_data = SliceW'(1 << tgt_q);
        state_d  = S_EMIT;
      end

      // Look at the head of the current level.
      S_SCH_SCAN: begin
        if (cnt_cur == '0) begin
          if (lvl_last) state_d = S_EMIT;
          else          lvl_d   = lvl_nx;
        end else begin
          pid_d   = ent_cur;
          state_d = S_SCH_UNUSED;
        end
      end

      // Drop an unused head; the next head is then taken unchecked for unused.
      S_SCH_UNUSED: begin
        if (unused_q[pid_q]) begin
          heads_d[lvl_q]  = ring_next(head_cur);
          counts_d[lvl_q] = cnt_cur - 1'b1;
          if (cnt_cur == CntW'(1)) begin
            if (lvl_last) begin
              state_d = S_EMIT;
            end else begin
              lvl_d   = lvl_nx;
              state_d = S_SCH_SCAN;
            end
          end else begin
            state_d = S_SCH_REREAD;
          end
        end else begin
          state_d = S_SCH_BLOCKED;
        end
      end

      S_SCH_REREAD: begin
        pid_d   = ent_cur;
        state_d = S_SCH_BLOCKED;
      end

      // Rotate a blocked head to the back of its level once.
      S_SCH_BLOCKED: begin
        if (blocked_q[pid_q]) begin
          ent_we         = 1'b1;
          heads_d[lvl_q] = ring_next(head_cur);
          tails_d[lvl_q] = ring_next(tail_cur);
          state_d        = S_SCH_ROT;
        end else begin
          state_d = S_SCH_TAKE;
        end
      end

      // The new head is taken unchecked; if it is the rotated slot, skip on.
      S_SCH_ROT: begin
        if (ent_cur == pid_q) begin
          if (lvl_last) begin
            state_d = S_EMIT;
          end else begin
            lvl_d   = lvl_nx;
            state_d = S_SCH_SCAN;
          end
        end else begin
          pid_d   = ent_cur;
          state_d = S_SCH_TAKE;
        end
      end

      // Charge the slot one tick and demote it when its slice runs out.
      S_SCH_TAKE: begin
        res_slot_d = pid_q;
        state_d    = S_EMIT;
        if (pid_ok) begin
          slc_we = 1'b1;
          if (slice_dec == '0) begin
            res_dem_d      = 1'b1;
            slc_data       = SliceW'(1 << lvl_dem);
            heads_d[lvl_q] = ring_next(head_cur);
            if (lvl_last) begin
              ent_we         = 1'b1;
              tails_d[lvl_q] = ring_next(tail_cur);
            end else begin
              counts_d[lvl_q] = cnt_cur - 1'b1;
              if (counts_q[lvl_nx] < CntFull) begin
                ent_we           = 1'b1;
                ent_lvl          = lvl_nx;
                ent_ptr          = tails_q[lvl_nx];
                tails_d[lvl_nx]  = ring_next(tails_q[lvl_nx]);
                counts_d[lvl_nx] = counts_q[lvl_nx] + 1'b1;
              end
            end
          end
        end
      end

      // Hand the result to the output register once it is free.
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state and queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        heads_q[l]  <= '0;
        tails_q[l]  <= '0;
        counts_q[l] <= '0;
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slices_q[s] <= '0;
      end
    end else begin
      state_q  <= state_d;
      heads_q  <= heads_d;
      tails_q  <= tails_d;
      counts_q <= counts_d;
      if (slc_we) slices_q[slc_idx] <= slc_data;
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    rem_q      <= rem_d;
    pid_q      <= pid_d;
    id_q       <= id_d;
    tgt_q      <= tgt_d;
    unused_q   <= unused_d;
    blocked_q  <= blocked_d;
    res_slot_q <= res_slot_d;
    res_dem_q  <= res_dem_d;
    if (ent_we) entries_q[ent_lvl][ent_ptr] <= ent_data;
    if (state_q == S_EMIT && out_free) begin
      out_slot_q <= res_slot_q;
      out_dem_q  <= res_dem_q;
    end
  end

  // While compacting, the entries left to read never outnumber the level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REQ_SCAN) |-> (rem_q <= counts_q[lvl_q]))
    else $error("requeue scan count exceeds level occupancy");

  // A slot is charged only from a level that holds entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCH_TAKE) |-> (counts_q[lvl_q] != '0))
    else $error("schedule took a slot from an empty level");

  // A finished command always produces a word on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (out_valid_o && in_ready_o))
    else $error("result word not delivered");

endmodule

>>> bench/multilevel_feedback_queue_scheduler_tb.sv
// Self-checking testbench of the multilevel feedback queue scheduler.
module multilevel_feedback_queue_scheduler_tb;
  import mlfq_pkg::*;

  localparam int NumSlots     = 8;
  localparam int NumLevels    = 4;
  localparam int HalfPeriod   = 10;
  localparam int ResetCycles  = 9;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 60;
  localparam int CycleLimit   = 200000;
  localparam int MaxReports   = 10;
  // The command field has one code beyond those the block knows; it must do nothing.
  localparam logic [CmdW-1:0] CmdReserved = 2'd3;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i       = '0;
  logic [SlotIdW-1:0]  slot_id_i       = '0;
  logic [PrioW-1:0]    slot_priority_i = '0;
  logic [MaskW-1:0]    unused_mask_i   = '0;
  logic [MaskW-1:0]    blocked_mask_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [SlotIdW-1:0]  next_slot_o;
  logic                demoted_o;

  int cycles      = 0;
  int hold_asked  = 0;

  // Tracks the queues and slices and keeps the slot picks still owed by the block.
  class sched_ledger;
    logic [SlotIdW-1:0] ring [NumLevels][NumSlots];
    int                 head [NumLevels];
    int                 tail [NumLevels];
    int                 fill [NumLevels];
    logic [SliceW-1:0]  slice [NumSlots];
    logic [SlotIdW-1:0] slot_due [$];
    logic               demote_due [$];
    int                 faults;

    function new();
      wipe_levels();
      foreach (slice[s]) slice[s] = '0;
      faults = 0;
    endfunction

    function void wipe_levels();
      for (int l = 0; l < NumLevels; l++) begin
        for (int s = 0; s < NumSlots; s++) ring[l][s] = '0;
        head[l] = 0;
        tail[l] = 0;
        fill[l] = 0;
      end
    endfunction

    function void drop_head(int l);
      if (fill[l] == 0) return;
      ring[l][head[l]] = '0;
      head[l] = (head[l] + 1) % NumSlots;
      fill[l]--;
    endfunction

    function void push_tail(int l, logic [SlotIdW-1:0] id);
      if (fill[l] >= NumSlots) return;
      ring[l][tail[l]] = id;
      tail[l] = (tail[l] + 1) % NumSlots;
      fill[l]++;
    endfunction

    function logic [SlotIdW-1:0] head_slot(int l);
      return ring[l][head[l]];
    endfunction

    // Take a slot out of every level; the remaining entries keep their order.
    function void purge_slot(logic [SlotIdW-1:0] id);
      logic [SlotIdW-1:0] keep [NumSlots];
      logic [SlotIdW-1:0] t;
      int n;
      for (int l = 0; l < NumLevels; l++) begin
        n = 0;
        while (fill[l] != 0) begin
          t = head_slot(l);
          drop_head(l);
          if (t != id && n < NumSlots) begin
            keep[n] = t;
            n++;
          end
        end
        for (int k = 0; k < n; k++) push_tail(l, keep[k]);
      end
    endfunction

    // Apply one accepted command word and queue the result it must produce.
    function void note_word(logic [CmdW-1:0] cmd, logic [SlotIdW-1:0] id,
                            logic [PrioW-1:0] prio, logic [MaskW-1:0] unused,
                            logic [MaskW-1:0] blocked);
      logic [SlotIdW-1:0] pick;
      logic [SlotIdW-1:0] nxt;
      logic [SlotIdW-1:0] chosen;
      logic               dem;
      int                 q;
      int                 lvl;
      int                 nl;
      int                 l;
      chosen = '0;
      dem    = 1'b0;
      if (cmd == CMD_CLEAR) begin
        wipe_levels();
      end else if (cmd == CMD_REQUEUE) begin
        q   = int'(prio) >> PrioShift;
        lvl = (q >= NumLevels - 1) ? 0 : NumLevels - 1 - q;
        purge_slot(id);
        push_tail(lvl, id);
        slice[id] = SliceW'(1 << lvl);
      end else if (cmd == CMD_SCHEDULE) begin
        for (l = 0; l < NumLevels; l++) begin
          if (fill[l] == 0) continue;
          pick = head_slot(l);
          // An unused head is dropped and the next one is taken unchecked.
          if (unused[pick]) begin
            drop_head(l);
            if (fill[l] == 0) continue;
            pick = head_slot(l);
          end
          // A blocked head rotates once; a lone blocked slot skips the level.
          if (blocked[pick]) begin
            drop_head(l);
            push_tail(l, pick);
            nxt = head_slot(l);
            if (nxt == pick) continue;
            pick = nxt;
          end
          slice[pick] = slice[pick] - 1'b1;
          if (slice[pick] == '0) begin
            nl = (l + 1 < NumLevels) ? l + 1 : l;
            drop_head(l);
            push_tail(nl, pick);
            slice[pick] = SliceW'(1 << nl);
            dem = 1'b1;
          end
          chosen = pick;
          break;
        end
      end
      slot_due.push_back(chosen);
      demote_due.push_back(dem);
    endfunction

    // Compare one returned word with the oldest one owed.
    function void check_word(logic [SlotIdW-1:0] got_slot, logic got_dem);
      logic [SlotIdW-1:0] want_slot;
      logic               want_dem;
      if (slot_due.size() == 0) begin
        faults++;
        if (faults <= MaxReports)
          $display("unexpected word: slot %0d demoted %0d", got_slot, got_dem);
        return;
      end
      want_slot = slot_due.pop_front();
      want_dem  = demote_due.pop_front();
      if (got_slot !== want_slot || got_dem !== want_dem) begin
        faults++;
        if (faults <= MaxReports)
          $display("mismatch: expected slot %0d demoted %0d, got slot %0d demoted %0d",
                   want_slot, want_dem, got_slot, got_dem);
      end
    endfunction

    function int pending();
      return slot_due.size();
    endfunction

    function void close();
      if (slot_due.size() != 0) begin
        faults += slot_due.size();
        $display("%0d words never returned", slot_due.size());
      end
    endfunction
  endclass

  sched_ledger board;

  multilevel_feedback_queue_scheduler #(
    .NUM_SLOTS (NumSlots),
    .NUM_LEVELS(NumLevels)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .slot_id_i      (slot_id_i),
    .slot_priority_i(slot_priority_i),
    .unused_mask_i  (unused_mask_i),
    .blocked_mask_i (blocked_mask_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_slot_o    (next_slot_o),
    .demoted_o      (demoted_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  // Give up once the run takes far longer than any correct one could.
  initial begin
    wait (cycles >= CycleLimit);
    $display("multilevel_feedback_queue_scheduler_tb: errors");
    $finish;
  end

  // Note accepted command words and check returned words at each edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        board.note_word(command_i, slot_id_i, slot_priority_i, unused_mask_i,
                        blocked_mask_i);
      if (out_valid_o && out_ready_i)
        board.check_word(next_slot_o, demoted_o);
    end
  end

  // Result side: stalls in random modes, plus a long hold-off on request.
  initial begin : receiver
    int mode;
    int seg_left;
    int hold_left;
    int hold_seen;
    mode      = 0;
    seg_left  = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HoldCycles;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 80);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one command word and hold it until the block takes it.
  task automatic send_word(logic [CmdW-1:0] cmd, logic [SlotIdW-1:0] id,
                           logic [PrioW-1:0] prio, logic [MaskW-1:0] unused,
                           logic [MaskW-1:0] blocked);
    command_i       <= cmd;
    slot_id_i       <= id;
    slot_priority_i <= prio;
    unused_mask_i   <= unused;
    blocked_mask_i  <= blocked;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic requeue(logic [SlotIdW-1:0] id, logic [PrioW-1:0] prio);
    send_word(CMD_REQUEUE, id, prio, '0, '0);
  endtask

  task automatic schedule(logic [MaskW-1:0] unused, logic [MaskW-1:0] blocked);
    send_word(CMD_SCHEDULE, '0, '0, unused, blocked);
  endtask

  // Idle the command side; n is at least one.
  task automatic rest(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop offering until every owed word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Masks are mostly sparse so that schedules usually pick a slot.
  function automatic logic [MaskW-1:0] sparse_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return MaskW'($urandom);
      default: return MaskW'($urandom & $urandom & $urandom);
    endcase
  endfunction

  // Mostly requeues and schedules; clears and the reserved code are rare noise.
  task automatic send_random_word();
    int                r;
    logic [CmdW-1:0]   cmd;
    r = $urandom_range(0, 99);
    if (r < 4)       cmd = CMD_CLEAR;
    else if (r < 7)  cmd = CmdReserved;
    else if (r < 42) cmd = CMD_REQUEUE;
    else             cmd = CMD_SCHEDULE;
    if (cmd == CMD_SCHEDULE)
      send_word(cmd, SlotIdW'($urandom), PrioW'($urandom), sparse_mask(), sparse_mask());
    else
      send_word(cmd, SlotIdW'($urandom), PrioW'($urandom), MaskW'($urandom),
                MaskW'($urandom));
  endtask

  // Bursts of random length, now and then a long one without gaps.
  task automatic random_run(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_random_word();
      left -= burst;
      rest($urandom_range(1, 8));
    end
  endtask

  initial begin
    board = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle pick, reserved code, every level, masks, slot zero, clear.
    schedule('0, '0);
    send_word(CmdReserved, '1, '1, '1, '1);
    requeue(3'd7, 8'hFF);
    requeue(3'd3, 8'h40);
    requeue(3'd5, 8'h80);
    requeue(3'd0, 8'h00);
    requeue(3'd2, 8'h3F);
    schedule('0, '0);
    rest(2);
    schedule(8'h20, '0);
    schedule('0, 8'h80);
    requeue(3'd3, 8'hC0);
    schedule('1, '0);
    schedule('0, '1);
    requeue(3'd4, 8'h00);
    schedule('0, 8'h04);
    requeue(3'd0, 8'hFF);
    schedule('0, '0);
    rest(1);
    send_word(CMD_CLEAR, '1, '1, '1, '1);
    schedule('0, '0);
    send_word(CmdReserved, '0, '0, '0, '0);
    requeue(3'd1, 8'hBF);
    schedule('0, '0);
    schedule('0, '0);
    schedule('0, '0);
    drain();

    random_run(250);

    // Keep offering through a long result stall so the block backs up.
    hold_asked++;
    repeat (24) send_random_word();
    random_run(150);
    drain();
    random_run(200);

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    board.close();
    if (board.faults == 0) begin
      $display("multilevel_feedback_queue_scheduler_tb: clean");
    end else begin
      $display("multilevel_feedback_queue_scheduler_tb: errors");
    end
    $finish;
  end

endmodule
